FILE: design/gregorian_date_time_to_mjd_unit_macros.svh
// ----------------------------------------------------------------------------
// Gregorian date/time to MJD: assertion macros
// Shared concurrent assertion forms for the unit's checker.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_TIME_TO_MJD_UNIT_MACROS_SVH
`define GREGORIAN_DATE_TIME_TO_MJD_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define GDTM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdtm assertion failed");

// Next-cycle implication, disabled in reset
`define GDTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdtm assertion failed");

`endif

FILE: design/gdtm_pkg.sv
// ----------------------------------------------------------------------------
// gdtm_pkg
// Widths, constants, status codes and month tables for the Gregorian
// date/time to Modified Julian Date unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdtm_pkg;

    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int DAY_W      = 5;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int USEC_W     = 26;
    localparam int MJD_W      = 23;
    localparam int FRAC_OUT_W = 32;
    localparam int STAT_W     = 2;
    localparam int TOTAL_W    = 37;
    localparam int CENT_W     = 8;
    localparam int MTERM_W    = 9;

    localparam int FRACTION_BITS_DEF = 32;

    localparam logic [STAT_W-1:0] DATE_OK        = 2'd0;
    localparam logic [STAT_W-1:0] DATE_BAD_YEAR  = 2'd1;
    localparam logic [STAT_W-1:0] DATE_BAD_MONTH = 2'd2;
    localparam logic [STAT_W-1:0] DATE_BAD_DAY   = 2'd3;

    localparam logic [STAT_W-1:0] TIME_OK         = 2'd0;
    localparam logic [STAT_W-1:0] TIME_BAD_HOUR   = 2'd1;
    localparam logic [STAT_W-1:0] TIME_BAD_MINUTE = 2'd2;
    localparam logic [STAT_W-1:0] TIME_BAD_SECOND = 2'd3;

    localparam logic signed [YEAR_W-1:0] YEAR_MIN = -14'sd4699;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;

    localparam logic [USEC_W-1:0]  US_PER_MINUTE = 26'd60000000;
    localparam logic [TOTAL_W-1:0] US_PER_HOUR   = 37'd3600000000;
    localparam logic [TOTAL_W-1:0] US_PER_DAY    = 37'd86400000000;

    localparam logic [YEAR_W-1:0] YEAR_OFF_DAYS = 14'd4712;
    localparam logic [YEAR_W-1:0] YEAR_OFF_CENT = 14'd4900;
    localparam logic [YEAR_W-1:0] YEAR_OFF_LEAP = 14'd4800;

    localparam int                RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP_100  = 27'd5243;
    localparam int                RECIP_SHIFT = 19;

    localparam logic [24:0]      DAYS_PER_4Y = 25'd1461;
    localparam logic [MJD_W-1:0] MJD_BASE    = 23'd2399904;

    // day fraction by reciprocal multiply: the odd part of US_PER_DAY is the
    // divisor, and FRAC_K scale bits keep the floor exact for every total
    localparam int                 DAY_DIV_SHIFT = 13;
    localparam logic [TOTAL_W-1:0] DAY_DIV       = US_PER_DAY >> DAY_DIV_SHIFT;

    localparam int FRAC_K        = 61;
    localparam int FRAC_RECIP_W  = 96;
    localparam int RECIP_CHUNK_W = 32;
    localparam int FRAC_CHUNKS   = 3;
    localparam int FRAC_LO_W     = 19;
    localparam int FRAC_HI_W     = TOTAL_W - FRAC_LO_W;
    localparam int FRAC_PP_W     = FRAC_LO_W + RECIP_CHUNK_W;
    localparam int FRAC_SUM_W    = FRAC_K + FRAC_OUT_W;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // days from March 1 to the first of the month, March-based year
    function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] m);
        logic [MTERM_W-1:0] t;
        case (m)
            4'd1:    t = 9'd306;
            4'd2:    t = 9'd337;
            4'd3:    t = 9'd0;
            4'd4:    t = 9'd31;
            4'd5:    t = 9'd61;
            4'd6:    t = 9'd92;
            4'd7:    t = 9'd122;
            4'd8:    t = 9'd153;
            4'd9:    t = 9'd184;
            4'd10:   t = 9'd214;
            4'd11:   t = 9'd245;
            4'd12:   t = 9'd275;
            default: t = 9'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: design/gregorian_date_time_to_mjd_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_time_to_mjd_unit
// Pipeline: an input transaction passes the input, check, product and result
// registers in turn before its result transaction appears.
// Throughput: one transaction per cycle; each stage advances when empty or
// when the stage after it advances.
// Reset: rst_n clears every stage valid bit; no results pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_time_to_mjd_unit
    import gdtm_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [YEAR_W-1:0]   year,
    input  logic [MONTH_W-1:0]         month,
    input  logic [DAY_W-1:0]           day,
    input  logic [HOUR_W-1:0]          hour,
    input  logic [MINUTE_W-1:0]        minute,
    input  logic [USEC_W-1:0]          microsecond,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [MJD_W-1:0]    mjd_day,
    output logic [FRAC_OUT_W-1:0]      day_fraction,
    output logic [STAT_W-1:0]          date_status,
    output logic [STAT_W-1:0]          time_status
);

    localparam int RECIP_EXP = FRACTION_BITS + FRAC_K - DAY_DIV_SHIFT;
    localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP =
        FRAC_RECIP_W'(((128'd1 << RECIP_EXP) + 128'(DAY_DIV) - 128'd1) / 128'(DAY_DIV));
    localparam logic [RECIP_CHUNK_W-1:0] RECIP_C0 = FRAC_RECIP[RECIP_CHUNK_W-1:0];
    localparam logic [RECIP_CHUNK_W-1:0] RECIP_C1 =
        FRAC_RECIP[2*RECIP_CHUNK_W-1:RECIP_CHUNK_W];
    localparam logic [RECIP_CHUNK_W-1:0] RECIP_C2 =
        FRAC_RECIP[3*RECIP_CHUNK_W-1:2*RECIP_CHUNK_W];

    logic                      in_vld_reg;
    logic signed [YEAR_W-1:0]  in_year_reg;
    logic [MONTH_W-1:0]        in_month_reg;
    logic [DAY_W-1:0]          in_day_reg;
    logic [HOUR_W-1:0]         in_hour_reg;
    logic [MINUTE_W-1:0]       in_minute_reg;
    logic [USEC_W-1:0]         in_usec_reg;

    logic                      p_vld_reg;
    logic [STAT_W-1:0]         p_dstat_reg;
    logic [STAT_W-1:0]         p_tstat_reg;
    logic [YEAR_W-1:0]         p_yoff_reg;
    logic [CENT_W-1:0]         p_cent_reg;
    logic [MTERM_W-1:0]        p_mterm_reg;
    logic [DAY_W-1:0]          p_day_reg;
    logic [TOTAL_W-1:0]        p_total_reg;

    logic [STAT_W-1:0]         p_dstat_next;
    logic [STAT_W-1:0]         p_tstat_next;
    logic [YEAR_W-1:0]         p_yoff_next;
    logic [CENT_W-1:0]         p_cent_next;
    logic [TOTAL_W-1:0]        p_total_next;

    logic                      early;
    logic [YEAR_W-1:0]         ycent_x;
    logic [YEAR_W-1:0]         yleap_x;
    logic [RECIP_W-1:0]        cent_prod;
    logic [RECIP_W-1:0]        leap_prod;
    logic [CENT_W-1:0]         leap_q;
    logic                      div100;
    logic                      leap;
    logic [DAY_W-1:0]          mlen;
    logic [TOTAL_W-1:0]        total;

    logic [24:0]               yprod;
    logic [9:0]                cprod;
    logic [MJD_W-1:0]          mjd_sum;
    logic [MJD_W-1:0]          mjd_calc;

    logic [FRAC_LO_W-1:0]      t_lo;
    logic [FRAC_HI_W-1:0]      t_hi;
    logic [FRAC_PP_W-1:0]      m_pp_next [2*FRAC_CHUNKS];

    logic                      m_vld_reg;
    logic [FRAC_PP_W-1:0]      m_pp_reg  [2*FRAC_CHUNKS];
    logic [MJD_W-1:0]          m_mjd_reg;
    logic [STAT_W-1:0]         m_dstat_reg;
    logic [STAT_W-1:0]         m_tstat_reg;

    logic [FRAC_SUM_W-1:0]     frac_sum;
    logic [FRAC_OUT_W-1:0]     o_frac_next;

    logic                      o_vld_reg;
    logic [MJD_W-1:0]          o_mjd_reg;
    logic [FRAC_OUT_W-1:0]     o_frac_reg;
    logic [STAT_W-1:0]         o_dstat_reg;
    logic [STAT_W-1:0]         o_tstat_reg;

    logic                      ld_o;
    logic                      ld_m;
    logic                      ld_p;
    logic                      ld_in;

    // ---------------- flow control ----------------
    assign ld_o     = !o_vld_reg || out_ready;
    assign ld_m     = !m_vld_reg || ld_o;
    assign ld_p     = !p_vld_reg || ld_m;
    assign ld_in    = !in_vld_reg || ld_p;
    assign in_ready = ld_in;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (ld_in)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_in)
        begin
            in_year_reg   <= year;
            in_month_reg  <= month;
            in_day_reg    <= day;
            in_hour_reg   <= hour;
            in_minute_reg <= minute;
            in_usec_reg   <= microsecond;
        end
    end

    // ---------------- date and time checks ----------------
    always_comb
    begin
        early     = (in_month_reg == MONTH_JAN) || (in_month_reg == MONTH_FEB);
        p_yoff_next = in_year_reg + YEAR_OFF_DAYS - YEAR_W'(early);
        ycent_x   = in_year_reg + YEAR_OFF_CENT - YEAR_W'(early);
        yleap_x   = in_year_reg + YEAR_OFF_LEAP;
        cent_prod = RECIP_W'(ycent_x) * RECIP_100;
        leap_prod = RECIP_W'(yleap_x) * RECIP_100;
        p_cent_next = CENT_W'(cent_prod >> RECIP_SHIFT);
        leap_q    = CENT_W'(leap_prod >> RECIP_SHIFT);
        div100    = (yleap_x == YEAR_W'(YEAR_W'(leap_q) * YEAR_W'(100)));
        leap      = (in_year_reg[1:0] == 2'b00) && (!div100 || (leap_q[1:0] == 2'b00));
        mlen      = month_days(in_month_reg, leap);

        if (in_year_reg < YEAR_MIN)
        begin
            p_dstat_next = DATE_BAD_YEAR;
        end
        else if ((in_month_reg == '0) || (in_month_reg > MONTH_DEC))
        begin
            p_dstat_next = DATE_BAD_MONTH;
        end
        else if ((in_day_reg == '0) || (in_day_reg > mlen))
        begin
            p_dstat_next = DATE_BAD_DAY;
        end
        else
        begin
            p_dstat_next = DATE_OK;
        end

        if (in_usec_reg >= US_PER_MINUTE)
        begin
            p_tstat_next = TIME_BAD_SECOND;
        end
        else if (in_minute_reg > MINUTE_MAX)
        begin
            p_tstat_next = TIME_BAD_MINUTE;
        end
        else if (in_hour_reg > HOUR_MAX)
        begin
            p_tstat_next = TIME_BAD_HOUR;
        end
        else
        begin
            p_tstat_next = TIME_OK;
        end

        total = TOTAL_W'(in_hour_reg) * US_PER_HOUR
              + TOTAL_W'(in_minute_reg) * TOTAL_W'(US_PER_MINUTE)
              + TOTAL_W'(in_usec_reg);
        p_total_next = (p_tstat_next == TIME_OK) ? total : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (ld_p)
        begin
            p_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_p)
        begin
            p_dstat_reg <= p_dstat_next;
            p_tstat_reg <= p_tstat_next;
            p_yoff_reg  <= p_yoff_next;
            p_cent_reg  <= p_cent_next;
            p_mterm_reg <= month_term(in_month_reg);
            p_day_reg   <= in_day_reg;
            p_total_reg <= p_total_next;
        end
    end

    // ---------------- day number ----------------
    always_comb
    begin
        yprod   = 25'(p_yoff_reg) * DAYS_PER_4Y;
        cprod   = 10'(p_cent_reg) * 10'd3;
        mjd_sum = MJD_W'(yprod >> 2) + MJD_W'(p_mterm_reg) - MJD_W'(cprod >> 2)
                + MJD_W'(p_day_reg) - MJD_BASE;
        mjd_calc = ((p_dstat_reg == DATE_BAD_YEAR) || (p_dstat_reg == DATE_BAD_MONTH))
                 ? '0 : mjd_sum;
    end

    // ---------------- fraction partial products ----------------
    always_comb
    begin
        t_lo         = p_total_reg[FRAC_LO_W-1:0];
        t_hi         = p_total_reg[TOTAL_W-1:FRAC_LO_W];
        m_pp_next[0] = FRAC_PP_W'(t_lo) * FRAC_PP_W'(RECIP_C0);
        m_pp_next[1] = FRAC_PP_W'(t_lo) * FRAC_PP_W'(RECIP_C1);
        m_pp_next[2] = FRAC_PP_W'(t_lo) * FRAC_PP_W'(RECIP_C2);
        m_pp_next[3] = FRAC_PP_W'(t_hi) * FRAC_PP_W'(RECIP_C0);
        m_pp_next[4] = FRAC_PP_W'(t_hi) * FRAC_PP_W'(RECIP_C1);
        m_pp_next[5] = FRAC_PP_W'(t_hi) * FRAC_PP_W'(RECIP_C2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (ld_m)
        begin
            m_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_m)
        begin
            for (int j = 0; j < 2*FRAC_CHUNKS; j++)
            begin
                m_pp_reg[j] <= m_pp_next[j];
            end
            m_mjd_reg   <= mjd_calc;
            m_dstat_reg <= p_dstat_reg;
            m_tstat_reg <= p_tstat_reg;
        end
    end

    // ---------------- fraction sum ----------------
    always_comb
    begin
        frac_sum = FRAC_SUM_W'(m_pp_reg[0])
                 + (FRAC_SUM_W'(m_pp_reg[1]) << RECIP_CHUNK_W)
                 + (FRAC_SUM_W'(m_pp_reg[2]) << (2*RECIP_CHUNK_W))
                 + (FRAC_SUM_W'(m_pp_reg[3]) << FRAC_LO_W)
                 + (FRAC_SUM_W'(m_pp_reg[4]) << (FRAC_LO_W + RECIP_CHUNK_W))
                 + (FRAC_SUM_W'(m_pp_reg[5]) << (FRAC_LO_W + 2*RECIP_CHUNK_W));
        o_frac_next = frac_sum[FRAC_SUM_W-1:FRAC_K];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (ld_o)
        begin
            o_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_o)
        begin
            o_mjd_reg   <= m_mjd_reg;
            o_frac_reg  <= o_frac_next;
            o_dstat_reg <= m_dstat_reg;
            o_tstat_reg <= m_tstat_reg;
        end
    end

    // ---------------- result ----------------
    assign out_valid    = o_vld_reg;
    assign mjd_day      = o_mjd_reg;
    assign day_fraction = o_frac_reg;
    assign date_status  = o_dstat_reg;
    assign time_status  = o_tstat_reg;

endmodule

`default_nettype wire

FILE: design/gdtm_chk.sv
// ----------------------------------------------------------------------------
// gdtm_chk
// Port-level checker for the date/time to MJD unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gregorian_date_time_to_mjd_unit_macros.svh"

module gdtm_chk
    import gdtm_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic signed [MJD_W-1:0] mjd_day,
    input wire logic [FRAC_OUT_W-1:0]   day_fraction,
    input wire logic [STAT_W-1:0]       date_status,
    input wire logic [STAT_W-1:0]       time_status
);

    `GDTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    `GDTM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(mjd_day) && $stable(day_fraction) && $stable(date_status) && $stable(time_status))

    `GDTM_ASSERT_NOW(a_bad_time_zero, out_valid && (time_status != TIME_OK), day_fraction == '0)

    `GDTM_ASSERT_NOW(a_bad_date_zero, out_valid && ((date_status == DATE_BAD_YEAR) || (date_status == DATE_BAD_MONTH)), mjd_day == '0)

    `GDTM_ASSERT_NOW(a_stall_only_full, !in_ready, out_valid && !out_ready)

endmodule

bind gregorian_date_time_to_mjd_unit gdtm_chk u_gdtm_chk (.*);

`default_nettype wire

FILE: verif/gregorian_date_time_to_mjd_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_time_to_mjd_unit_tb
// Drives Gregorian dates and times of day through the unit, with random idle
// cycles on both handshakes. A scoreboard converts every accepted input
// transaction to an expected MJD day number, day fraction and status pair,
// and compares each result transaction against the oldest one waiting.
// ----------------------------------------------------------------------------
module gregorian_date_time_to_mjd_unit_tb;

    import gdtm_pkg::*;

    localparam int FRAC_BITS   = FRACTION_BITS_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int NUM_RANDOM  = 1300;
    localparam int MAX_REPORTS = 10;
    localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MINUTE_W-1:0]      minute;
        logic [USEC_W-1:0]        microsecond;
    } date_time_t;

    typedef struct packed {
        logic signed [MJD_W-1:0] mjd_day;
        logic [FRAC_OUT_W-1:0]   day_fraction;
        logic [STAT_W-1:0]       date_status;
        logic [STAT_W-1:0]       time_status;
    } mjd_result_t;

    class mjd_result_board;
        mjd_result_t expected_q[$];
        int          mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function mjd_result_t convert(date_time_t dt);
            mjd_result_t r;
            int          y;
            int          m;
            int          d;
            int          mlen;
            int          ya;
            bit          leap;
            longint      mjd_full;
            logic [95:0] total_us;
            logic [95:0] scaled;
            y = int'($signed(dt.year));
            m = int'(dt.month);
            d = int'(dt.day);
            r = '0;
            if (y < int'(YEAR_MIN)) begin
                r.date_status = DATE_BAD_YEAR;
            end
            else if (m < int'(MONTH_JAN) || m > int'(MONTH_DEC)) begin
                r.date_status = DATE_BAD_MONTH;
            end
            else begin
                leap = ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
                mlen = DAYS_IN_MONTH[m-1];
                if (m == int'(MONTH_FEB) && leap)
                    mlen = 29;
                r.date_status = (d < 1 || d > mlen) ? DATE_BAD_DAY : DATE_OK;
                ya = y - (12 - m) / 10;
                mjd_full = (longint'(1461) * (ya + 4712)) / 4
                         + (306 * ((m + 9) % 12) + 5) / 10
                         - (3 * ((ya + 4900) / 100)) / 4
                         + d - 2399904;
                r.mjd_day = mjd_full[MJD_W-1:0];
            end
            if (dt.microsecond >= US_PER_MINUTE) begin
                r.time_status = TIME_BAD_SECOND;
            end
            else if (dt.minute > MINUTE_MAX) begin
                r.time_status = TIME_BAD_MINUTE;
            end
            else if (dt.hour > HOUR_MAX) begin
                r.time_status = TIME_BAD_HOUR;
            end
            else begin
                total_us = 96'(dt.hour) * 96'd3600000000 + 96'(dt.minute) * 96'd60000000
                         + 96'(dt.microsecond);
                scaled = (total_us << FRAC_BITS) / 96'd86400000000;
                r.time_status = TIME_OK;
                r.day_fraction = scaled[FRAC_OUT_W-1:0];
            end
            return r;
        endfunction

        function void note_date_time(date_time_t dt);
            expected_q.push_back(convert(dt));
        endfunction

        function void check_mjd_result(mjd_result_t got);
            mjd_result_t want;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected mjd result: mjd_day %0d frac %h date %0d time %0d",
                             got.mjd_day, got.day_fraction, got.date_status,
                             got.time_status);
                return;
            end
            want = expected_q.pop_front();
            if (got.mjd_day !== want.mjd_day || got.day_fraction !== want.day_fraction
                || got.date_status !== want.date_status
                || got.time_status !== want.time_status) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mjd result mismatch: expected mjd_day %0d frac %h date %0d time %0d, got mjd_day %0d frac %h date %0d time %0d",
                             want.mjd_day, want.day_fraction, want.date_status,
                             want.time_status, got.mjd_day, got.day_fraction,
                             got.date_status, got.time_status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [YEAR_W-1:0] year = '0;
    logic [MONTH_W-1:0]       month = '0;
    logic [DAY_W-1:0]         day = '0;
    logic [HOUR_W-1:0]        hour = '0;
    logic [MINUTE_W-1:0]      minute = '0;
    logic [USEC_W-1:0]        microsecond = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [MJD_W-1:0]  mjd_day;
    logic [FRAC_OUT_W-1:0]    day_fraction;
    logic [STAT_W-1:0]        date_status;
    logic [STAT_W-1:0]        time_status;

    mjd_result_board board;
    int              in_idle_pct = 30;
    int              out_idle_pct = 30;
    int              idle_cycles = 0;

    gregorian_date_time_to_mjd_unit #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .year         (year),
        .month        (month),
        .day          (day),
        .hour         (hour),
        .minute       (minute),
        .microsecond  (microsecond),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mjd_day      (mjd_day),
        .day_fraction (day_fraction),
        .date_status  (date_status),
        .time_status  (time_status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                board.note_date_time(date_time_t'{year, month, day, hour, minute,
                                                  microsecond});
            if (out_valid && out_ready)
                board.check_mjd_result(mjd_result_t'{mjd_day, day_fraction, date_status,
                                                     time_status});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic date_time_t make_dt(int y, int mo, int d, int h, int mi, int us);
        date_time_t dt;
        dt.year        = y[YEAR_W-1:0];
        dt.month       = mo[MONTH_W-1:0];
        dt.day         = d[DAY_W-1:0];
        dt.hour        = h[HOUR_W-1:0];
        dt.minute      = mi[MINUTE_W-1:0];
        dt.microsecond = us[USEC_W-1:0];
        return dt;
    endfunction

    // enter and leave at a falling edge
    task automatic send_date_time(input date_time_t dt);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        year        <= dt.year;
        month       <= dt.month;
        day         <= dt.day;
        hour        <= dt.hour;
        minute      <= dt.minute;
        microsecond <= dt.microsecond;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    initial
    begin
        date_time_t dt;
        int         kind;
        int         corner_years [8] = '{-4700, -4699, -8192, 8191, 1900, 2000, -100, 0};
        int         corner_usec [4] = '{0, 59999999, 60000000, 63999999};
        board = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_date_time(make_dt(-4699, 1, 1, 0, 0, 0));
        send_date_time(make_dt(-4700, 6, 15, 12, 0, 0));
        send_date_time(make_dt(-8192, 15, 0, 31, 63, 63999999));
        send_date_time(make_dt(8191, 12, 31, 23, 59, 59999999));
        send_date_time(make_dt(2020, 0, 10, 1, 2, 3));
        send_date_time(make_dt(2020, 13, 10, 1, 2, 3));
        send_date_time(make_dt(8191, 15, 31, 0, 0, 0));
        send_date_time(make_dt(1999, 5, 0, 6, 30, 0));
        send_date_time(make_dt(1999, 4, 31, 6, 30, 0));
        send_date_time(make_dt(2000, 2, 29, 0, 0, 1));
        send_date_time(make_dt(1900, 2, 29, 0, 0, 1));
        send_date_time(make_dt(2024, 2, 29, 8, 8, 8));
        send_date_time(make_dt(2023, 2, 29, 8, 8, 8));
        send_date_time(make_dt(-4, 2, 29, 3, 3, 3));
        send_date_time(make_dt(-100, 2, 29, 3, 3, 3));
        send_date_time(make_dt(0, 2, 29, 3, 3, 3));
        send_date_time(make_dt(1858, 11, 17, 0, 0, 0));
        send_date_time(make_dt(2000, 1, 1, 0, 0, 60000000));
        send_date_time(make_dt(2000, 1, 1, 31, 63, 63999999));
        send_date_time(make_dt(2000, 1, 1, 31, 60, 0));
        send_date_time(make_dt(2000, 1, 1, 24, 59, 59999999));
        send_date_time(make_dt(2000, 1, 1, 31, 0, 0));
        send_date_time(make_dt(2000, 1, 1, 12, 0, 0));
        send_date_time(make_dt(-1, 3, 1, 18, 0, 33554432));

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n >= 400 && n < 700) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            else begin
                in_idle_pct  = 30;
                out_idle_pct = 30;
            end
            if (n == 900) begin
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (board.pending() != 0);
            end
            kind = $urandom_range(99);
            if (kind < 70) begin
                dt = make_dt(int'($urandom_range(12890)) - 4699, $urandom_range(1, 12),
                             $urandom_range(1, 31), $urandom_range(23),
                             $urandom_range(59), $urandom_range(59999999));
            end
            else if (kind < 85) begin
                dt = make_dt($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                             $urandom_range(31), $urandom_range(63),
                             $urandom_range(63999999));
            end
            else begin
                dt = make_dt(corner_years[$urandom_range(7)] + $urandom_range(4),
                             $urandom_range(1, 3), $urandom_range(28, 31),
                             $urandom_range(23, 24), $urandom_range(59, 60),
                             corner_usec[$urandom_range(3)]);
            end
            send_date_time(dt);
        end

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (FRAC_BITS + 12) @(posedge clk);
        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
